// File: rtl/afd_pkg.sv
`timescale 1ns / 1ps
// afd_pkg: phase and event codes, result record and register reset values
// for the api frame deframer; no dependencies
package afd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h7E;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 16'h0060;
  localparam logic [BYTE_W-1:0] SUM_GOOD = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 8'd1;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_DISCARD = 3'd0,
    EV_HEADER  = 3'd1,
    EV_LENGTH  = 3'd2,
    EV_PAYLOAD = 3'd3,
    EV_GOOD    = 3'd4,
    EV_BADSUM  = 3'd5,
    EV_TOOLONG = 3'd6
  } event_t;

  typedef struct packed {
    event_t            ev;
    logic [LEN_W-1:0]  flen;
    logic [LEN_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } result_t;

endpackage

// File: rtl/api_frame_deframer.sv
`timescale 1ns / 1ps
// api_frame_deframer: finds header / length / payload / checksum frames in a
// byte stream and reports one event per byte; depends on afd_pkg
//
//  channel   | signals                                   | moves
//  ----------+-------------------------------------------+-------------------------------
//  s_axis    | tvalid tready tdata[7:0]                  | one received byte per request
//  m_axis    | tvalid tready tdata[39:0] tuser[2:0]      | one event per received byte
//  cfg       | cfg_valid cfg_ready cfg_index cfg_data    | register write, always ready
//
// one byte is taken per cycle while s_axis_tready is high, and its event is
// registered when the byte is accepted. the frame state updates in a single pass
// of compare, 16-bit count and 8-bit add logic between the byte and the result register.
// a two-entry output (result register plus skid register) lets the input
// keep flowing while a result waits; s_axis_tready drops only when both hold.
// synchronous reset returns the frame state to header hunt, empties the
// output and loads the register defaults (header 0x7E, max payload 96).
module api_frame_deframer (
  input  logic                               clk,
  input  logic                               rst,
  // byte stream in
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [afd_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] in_byte
  // events out
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] data_byte, [23:8] payload_index, [39:24] frame_length
  output logic [39:0]                        m_axis_tdata,
  output logic [afd_pkg::EVENT_W-1:0]        m_axis_tuser,   // [2:0] event_res
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [afd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import afd_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0] header_value;
  logic [LEN_W-1:0]  max_payload;

  // frame state
  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  payload_length, payload_length_next;
  logic [LEN_W-1:0]  byte_count, byte_count_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;

  // output stage
  result_t res;
  result_t out_reg;
  result_t skid_reg;
  logic    out_valid;
  logic    skid_valid;

  logic              in_fire;
  logic              out_fire;
  logic [BYTE_W-1:0] b;
  logic [LEN_W-1:0]  len_lo;
  logic [LEN_W-1:0]  count_inc;
  logic [BYTE_W-1:0] sum_inc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid && m_axis_tready;
  assign b             = s_axis_tdata;

  assign len_lo    = {payload_length[LEN_W-1:BYTE_W], b};
  assign count_inc = byte_count + 16'd1;
  assign sum_inc   = running_sum + b;

  // register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
      max_payload  <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_HEADER_VALUE) begin
        header_value <= cfg_data[BYTE_W-1:0];
      end else if (cfg_index == REG_MAX_PAYLOAD) begin
        max_payload <= cfg_data;
      end
    end
  end

  // per-byte frame decode
  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    byte_count_next     = byte_count;
    running_sum_next    = running_sum;
    res.ev   = EV_DISCARD;
    res.data = b;
    res.idx  = '0;
    res.flen = '0;
    unique case (phase)
      PH_LEN_HI: begin
        payload_length_next = {b, {BYTE_W{1'b0}}};
        res.ev   = EV_LENGTH;
        res.flen = {b, {BYTE_W{1'b0}}};
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = len_lo;
        res.flen         = len_lo;
        byte_count_next  = '0;
        running_sum_next = '0;
        if (len_lo > max_payload) begin
          res.ev     = EV_TOOLONG;
          phase_next = PH_HUNT;
        end else begin
          res.ev     = EV_LENGTH;
          phase_next = (len_lo == '0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.ev   = EV_PAYLOAD;
        res.idx  = byte_count;
        res.flen = payload_length;
        running_sum_next = sum_inc;
        byte_count_next  = count_inc;
        if (count_inc >= payload_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res.flen   = payload_length;
        res.ev     = (sum_inc == SUM_GOOD) ? EV_GOOD : EV_BADSUM;
        phase_next = PH_HUNT;
      end
      default: begin
        // hunting, and any unused phase code
        if (b == header_value) begin
          res.ev     = EV_HEADER;
          phase_next = PH_LEN_HI;
        end else begin
          res.ev     = EV_DISCARD;
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      payload_length <= '0;
      byte_count     <= '0;
      running_sum    <= '0;
    end else if (in_fire) begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      byte_count     <= byte_count_next;
      running_sum    <= running_sum_next;
    end
  end

  // result register with skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (out_valid && !m_axis_tready) begin
        // result register busy and stalled: park the new event
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_valid && !m_axis_tready) begin
        skid_reg <= res;
      end else begin
        out_reg <= res;
      end
    end else if (out_fire && skid_valid) begin
      out_reg <= skid_reg;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_reg.ev;
  assign m_axis_tdata  = {out_reg.flen, out_reg.idx, out_reg.data};

endmodule

// File: rtl/afd_checker.sv
`timescale 1ns / 1ps
// afd_checker: port-level checks for api_frame_deframer, bound to the top
// level below; depends on afd_pkg
module afd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [39:0]                   m_axis_tdata,
  input logic [afd_pkg::EVENT_W-1:0]   m_axis_tuser
);
  import afd_pkg::*;

  // nothing comes out in the cycle right after reset
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_axis_tvalid)
    else $error("event valid right after reset");

  // a stalled event holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled event changed");

  // payload index stays below the frame length
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == EV_PAYLOAD) |->
      (m_axis_tdata[23:8] < m_axis_tdata[39:24]))
    else $error("payload index beyond frame length");

  // only payload events carry an index; hunt events carry no length
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != EV_PAYLOAD) |-> (m_axis_tdata[23:8] == '0))
    else $error("index on non-payload event");

  a_hunt_nolen: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == EV_DISCARD || m_axis_tuser == EV_HEADER)) |->
      (m_axis_tdata[39:24] == '0))
    else $error("length on hunt event");

endmodule

bind api_frame_deframer afd_checker u_afd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for api_frame_deframer, random and directed
// byte streams against a frame tracker kept in a small scoreboard class; uses afd_pkg
module testbench;
  import afd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned IDLE_PCT = 27;
  // index past the register list, written to confirm it is ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

  // expected events for each accepted byte, tracked from its own copy of the
  // frame state and the two registers
  class frame_scoreboard;
    logic [BYTE_W-1:0] hdr;
    logic [LEN_W-1:0]  max_len;
    phase_t            ph;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  count;
    logic [BYTE_W-1:0] sum;
    result_t           event_queue[$];

    function new();
      hdr = HEADER_RESET;
      max_len = MAX_PAYLOAD_RESET;
      ph = PH_HUNT;
      len = '0;
      count = '0;
      sum = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_HEADER_VALUE) hdr = val[BYTE_W-1:0];
      else if (idx == REG_MAX_PAYLOAD) max_len = val[LEN_W-1:0];
    endfunction

    // one accepted byte always yields exactly one event
    function void take_byte(logic [BYTE_W-1:0] b);
      result_t r;
      logic [BYTE_W-1:0] total;
      r.ev = EV_DISCARD;
      r.data = b;
      r.idx = '0;
      r.flen = '0;
      case (ph)
        PH_LEN_HI: begin
          len = {b, 8'h00};
          r.ev = EV_LENGTH;
          r.flen = len;
          ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len[7:0] = b;
          r.flen = len;
          count = '0;
          sum = '0;
          if (len > max_len) begin
            r.ev = EV_TOOLONG;
            ph = PH_HUNT;
          end else begin
            r.ev = EV_LENGTH;
            ph = (len == '0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          r.ev = EV_PAYLOAD;
          r.idx = count;
          r.flen = len;
          sum = sum + b;
          count = count + 16'd1;
          if (count >= len) ph = PH_CHECK;
        end
        PH_CHECK: begin
          r.flen = len;
          total = sum + b;
          r.ev = (total == SUM_GOOD) ? EV_GOOD : EV_BADSUM;
          ph = PH_HUNT;
        end
        default: begin
          // unknown phases fall back to header hunt
          if (b == hdr) begin
            r.ev = EV_HEADER;
            ph = PH_LEN_HI;
          end else begin
            ph = PH_HUNT;
          end
        end
      endcase
      event_queue.push_back(r);
    endfunction

    // empty string when the event matches the oldest expectation
    function string check_event(result_t got);
      result_t want;
      string why;
      if (event_queue.size() == 0)
        return $sformatf("event %0d byte %02h with no byte pending", got.ev, got.data);
      want = event_queue.pop_front();
      why = "";
      if (got.ev !== want.ev)
        why = {why, $sformatf(" event %0d/%0d", got.ev, want.ev)};
      if (got.data !== want.data)
        why = {why, $sformatf(" data %02h/%02h", got.data, want.data)};
      if (got.idx !== want.idx)
        why = {why, $sformatf(" index %0d/%0d", got.idx, want.idx)};
      if (got.flen !== want.flen)
        why = {why, $sformatf(" length %0d/%0d", got.flen, want.flen)};
      if (why != "") why = {"event field got/want:", why};
      return why;
    endfunction

    function int pending();
      return event_queue.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [EVENT_W-1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_scoreboard sb;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned sent_bytes = 0;
  bit calm = 1'b0;                 // set while neither side idles
  // header and limit the stimulus builds frames for
  logic [BYTE_W-1:0] cur_hdr = HEADER_RESET;
  logic [LEN_W-1:0]  cur_max = MAX_PAYLOAD_RESET;

  api_frame_deframer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] data_byte, [23:8] payload_index, [39:24] frame_length
    .m_axis_tuser  (m_axis_tuser),   // [2:0] event_res
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("api_frame_deframer: mismatch");
      $finish;
    end
  end

  // receiver stalls at random outside the calm stretch
  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic report(input string what);
    if (mismatches < 100) $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // check every event request as it is taken
  always @(posedge clk) begin
    result_t got;
    string why;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ev = event_t'(m_axis_tuser);
      got.data = m_axis_tdata[7:0];
      got.idx = m_axis_tdata[23:8];
      got.flen = m_axis_tdata[39:24];
      why = sb.check_event(got);
      if (why != "") report(why);
    end
  end

  // called and returns at a falling edge; valid stays high between back-to-back bytes
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_byte(b);
    sent_bytes++;
    @(negedge clk);
  endtask

  // stop sending and wait for every event to drain, then let the block settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // both registers plus a write to an index the block must ignore
  task automatic program_regs(input logic [BYTE_W-1:0] hdr, input logic [LEN_W-1:0] max_len);
    write_reg(REG_HEADER_VALUE, {8'h00, hdr});
    write_reg(REG_MAX_PAYLOAD, max_len);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    cur_hdr = hdr;
    cur_max = max_len;
  endtask

  // mostly short payloads, now and then one at the limit or up to 300 bytes
  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    int unsigned top;
    r = $urandom_range(0, 99);
    if (r < 75) top = 12;
    else if (r < 97) top = 40;
    else top = 300;
    if (top > cur_max) top = cur_max;
    if (r >= 97) return LEN_W'(top);
    return LEN_W'($urandom_range(0, top));
  endfunction

  function automatic logic [LEN_W-1:0] too_long_len();
    if ($urandom_range(0, 1) == 0) return cur_max + 16'd1;
    return LEN_W'($urandom_range(int'(cur_max) + 1, 65535));
  endfunction

  // header, length, payload and checksum; a rejected length stops after the length
  task automatic send_frame(input logic [LEN_W-1:0] plen, input bit sum_ok);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] chk;
    int hdr_pos;
    int i;
    sum = 8'h00;
    hdr_pos = -1;
    // header value buried in the payload now and then
    if (plen != 0 && $urandom_range(0, 4) == 0) hdr_pos = $urandom_range(0, plen - 1);
    send_byte(cur_hdr);
    send_byte(plen[15:8]);
    send_byte(plen[7:0]);
    if (plen > cur_max) return;
    for (i = 0; i < int'(plen); i++) begin
      b = (i == hdr_pos) ? cur_hdr : BYTE_W'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    chk = SUM_GOOD - sum;
    if (!sum_ok) chk = chk ^ BYTE_W'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  // well-formed frames dominate; the rest is bad sums, oversize lengths,
  // line noise and frames cut short
  task automatic run_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned sel;
    stop_at = sent_bytes + budget;
    while (sent_bytes < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        send_frame(pick_len(), 1'b1);
      end else if (sel < 75) begin
        send_frame(pick_len(), 1'b0);
      end else if (sel < 83 && cur_max != 16'hFFFF) begin
        send_frame(too_long_len(), 1'b1);
      end else if (sel < 92) begin
        repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
      end else begin
        send_byte(cur_hdr);
        repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset registers: header 0x7e, max payload 96
    send_byte(8'h00);                    // noise, both byte extremes
    send_byte(8'hFF);
    send_byte(HEADER_RESET);             // zero-length frame, good sum
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HEADER_RESET);             // zero-length frame, bad sum
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(HEADER_RESET);             // header value carried as payload data
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(HEADER_RESET);
    send_byte(8'h81);
    send_byte(HEADER_RESET);             // one past the limit, then hunt resumes
    send_byte(8'h00);
    send_byte(8'h61);
    send_byte(8'h12);
    send_byte(HEADER_RESET);             // largest length field
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_frame(MAX_PAYLOAD_RESET, 1'b1); // payload exactly at the limit

    run_traffic(380);

    // smallest settings: zero header, only empty payloads allowed
    settle();
    program_regs(8'h00, 16'h0000);
    run_traffic(330);

    // largest settings, with a stretch where neither side idles
    settle();
    program_regs(8'hFF, 16'hFFFF);
    calm = 1'b1;
    run_traffic(250);
    calm = 1'b0;
    run_traffic(100);

    // random header, small limit; the sender holds off once mid-stream
    settle();
    program_regs(BYTE_W'($urandom), LEN_W'($urandom_range(1, 40)));
    run_traffic(150);
    settle();
    run_traffic(150);

    // default header back with a limit that needs the high length byte
    settle();
    program_regs(HEADER_RESET, 16'd300);
    run_traffic(330);

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && sb.pending() == 0) begin
      $display("api_frame_deframer: match");
    end else begin
      $display("api_frame_deframer: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/afd_pkg.sv
rtl/api_frame_deframer.sv
rtl/afd_checker.sv
bench/testbench.sv
